FILE: hw/rtl/dac_voltage_command_builder_unit_assert.svh
// ----------------------------------------------------------------------------
// DAC voltage command builder assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DAC_VOLTAGE_COMMAND_BUILDER_UNIT_ASSERT_SVH
`define DAC_VOLTAGE_COMMAND_BUILDER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DVCB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DVCB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DVCB_ASSERT(label, clk, rst_n, prop, msg)
`define DVCB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/dvcb_pkg.sv
// ----------------------------------------------------------------------------
// DAC voltage command builder package
// Widths, scaling constants and shared types.
// ----------------------------------------------------------------------------
package dvcb_pkg;

    localparam int CHANNELS   = 4;
    localparam int N_CH       = (CHANNELS > 4) ? 4 : ((CHANNELS < 1) ? 1 : CHANNELS);
    localparam int CH_W       = (N_CH > 1) ? $clog2(N_CH) : 1;

    localparam int LEVEL_W    = 13;
    localparam int OFFSET_W   = 14;
    localparam int MAG_W      = 14;
    localparam int K_W        = 28;
    localparam int SHIFT      = 27;
    localparam int CODE_W     = 12;
    localparam int PROD_W     = MAG_W + K_W;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    typedef logic        [LEVEL_W-1:0]    t_level;
    typedef logic signed [OFFSET_W-1:0]   t_offset;
    typedef logic        [MAG_W-1:0]      t_mag;
    typedef logic        [K_W-1:0]        t_k;
    typedef logic        [CODE_W-1:0]     t_code;
    typedef logic        [BYTE_W-1:0]     t_byte;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_FOUR_MODE = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_OFFSET    = t_cfg_idx'(1);

    localparam t_level MV_CLIP_FOUR   = t_level'(5000);
    localparam t_level MV_CLIP_SINGLE = t_level'(4750);
    localparam t_level MV_SUBST       = t_level'(4500);
    localparam t_level MV_INT_REF     = t_level'(2048);

    localparam t_byte MULTI_WRITE   = 8'h40;
    localparam t_byte FLAG_INTERNAL = 8'h80;

    localparam longint FULL_SCALE = 4095;
    localparam longint D_INT      = 2048;
    localparam longint D_EXT      = 5000;
    localparam longint D_SGL      = 4750;

    // code = (mag * K) >> SHIFT, K rounded up: exact for every magnitude in range
    localparam t_k K_INT = t_k'((FULL_SCALE << SHIFT) / D_INT);
    localparam t_k K_EXT = t_k'(((FULL_SCALE << SHIFT) + D_EXT - 1) / D_EXT);
    localparam t_k K_SGL = t_k'(((FULL_SCALE << SHIFT) + D_SGL - 1) / D_SGL);

    typedef enum logic [1:0] {
        STEP_B0,
        STEP_B1,
        STEP_B2
    } t_step;

    typedef struct packed {
        logic                 four_mode;
        logic                 flag;
        logic                 neg;
        t_mag [N_CH-1:0]      mag;
    } t_cmd;

    typedef struct packed {
        logic head_valid;
        logic next_valid;
    } t_q_stat;

endpackage

FILE: hw/rtl/dvcb_ifs.sv
// ----------------------------------------------------------------------------
// DAC voltage command builder channels
// Level input channel and command byte output channel.
// ----------------------------------------------------------------------------
interface dvcb_level_if;
    import dvcb_pkg::*;

    logic   valid;
    logic   ready;
    t_level level_ch0;
    t_level level_ch1;
    t_level level_ch2;
    t_level level_ch3;

    modport source (output valid, output level_ch0, output level_ch1,
                    output level_ch2, output level_ch3, input ready);
    modport sink   (input valid, input level_ch0, input level_ch1,
                    input level_ch2, input level_ch3, output ready);
endinterface

interface dvcb_byte_if;
    import dvcb_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/dvcb_front.sv
// ----------------------------------------------------------------------------
// DAC voltage command builder front end
// Holds configuration, clips levels, picks the reference and forms queue entries.
// ----------------------------------------------------------------------------
module dvcb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dvcb_level_if.sink          i_level,
    input  logic                i_cfg_we,
    input  dvcb_pkg::t_cfg_idx  i_cfg_idx,
    input  dvcb_pkg::t_cfg_data i_cfg_data,
    input  logic                i_push_ready,
    output logic                o_push_valid,
    output dvcb_pkg::t_cmd      o_cmd
);
    import dvcb_pkg::*;

    logic                    r_four_mode;
    t_offset                 r_offset;

    t_level                  lv   [4];
    t_level                  clip [N_CH];
    t_level                  max_v;
    t_level                  c0;
    logic signed [MAG_W:0]   s;
    logic signed [MAG_W:0]   abs_s;
    logic                    neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_mode <= 1'b1;
            r_offset    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOUR_MODE: r_four_mode <= i_cfg_data[0];
                CFG_OFFSET:    r_offset    <= t_offset'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign lv[0] = i_level.level_ch0;
    assign lv[1] = i_level.level_ch1;
    assign lv[2] = i_level.level_ch2;
    assign lv[3] = i_level.level_ch3;

    always_comb begin
        max_v = '0;
        for (int i = 0; i < N_CH; i++) begin
            clip[i] = (lv[i] > MV_CLIP_FOUR) ? MV_SUBST : lv[i];
            if (clip[i] > max_v) begin
                max_v = clip[i];
            end
        end
    end

    always_comb begin
        c0    = (lv[0] > MV_CLIP_SINGLE) ? MV_SUBST : lv[0];
        s     = $signed({2'b00, c0}) + $signed({r_offset[OFFSET_W-1], r_offset});
        neg   = s[MAG_W];
        abs_s = neg ? -s : s;
    end

    always_comb begin
        o_cmd.four_mode = r_four_mode;
        o_cmd.flag      = (max_v < MV_INT_REF);
        o_cmd.neg       = r_four_mode ? 1'b0 : neg;
        for (int i = 0; i < N_CH; i++) begin
            o_cmd.mag[i] = t_mag'(clip[i]);
        end
        if (!r_four_mode) begin
            o_cmd.mag[0] = abs_s[MAG_W-1:0];
        end
    end

    assign o_push_valid  = i_level.valid;
    assign i_level.ready = i_push_ready;

endmodule

FILE: hw/rtl/dvcb_queue.sv
// ----------------------------------------------------------------------------
// DAC voltage command builder command queue
// Two-entry shifting queue between front end and byte sequencer.
// ----------------------------------------------------------------------------
module dvcb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    input  dvcb_pkg::t_cmd     i_cmd,
    output logic               o_push_ready,
    input  logic               i_pop,
    output dvcb_pkg::t_cmd     o_head,
    output dvcb_pkg::t_cmd     o_next,
    output dvcb_pkg::t_q_stat  o_stat
);
    import dvcb_pkg::*;

    t_cmd       r_slot0;
    t_cmd       r_slot1;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;

    assign o_push_ready = (r_count != 2'd2);
    assign push         = i_push_valid && o_push_ready;

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (r_count == 2'd2) begin
                r_slot0 <= r_slot1;
            end else if (push) begin
                r_slot0 <= i_cmd;
            end
        end else if (push) begin
            if (r_count == 2'd0) begin
                r_slot0 <= i_cmd;
            end else begin
                r_slot1 <= i_cmd;
            end
        end
    end

    assign o_head            = r_slot0;
    assign o_next            = r_slot1;
    assign o_stat.head_valid = (r_count != 2'd0);
    assign o_stat.next_valid = (r_count == 2'd2);

endmodule

FILE: hw/rtl/dvcb_back.sv
// ----------------------------------------------------------------------------
// DAC voltage command builder byte sequencer
// Scales channel codes one at a time and emits the command bytes.
// ----------------------------------------------------------------------------
`include "dac_voltage_command_builder_unit_assert.svh"

module dvcb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dvcb_pkg::t_cmd     i_head,
    input  dvcb_pkg::t_cmd     i_next,
    input  dvcb_pkg::t_q_stat  i_stat,
    output logic               o_pop,
    dvcb_byte_if.source        o_cmd
);
    import dvcb_pkg::*;

    logic              r_busy;
    logic              n_busy;
    logic [CH_W-1:0]   r_ch;
    logic [CH_W-1:0]   n_ch;
    t_step             r_step;
    t_step             n_step;
    t_code             r_code;
    logic              r_o_valid;
    t_byte             r_o_byte;
    logic              r_o_last;

    logic              emit;
    logic              four;
    logic              last_ch;
    logic              chan_end;
    logic              item_end;
    logic [1:0]        ch2;
    t_code             code_s;
    t_byte             byte_v;

    logic              load_en;
    t_cmd              src;
    logic [CH_W-1:0]   idx;
    t_k                m_k;
    logic [PROD_W-1:0] prod;

    assign emit     = r_busy && (!r_o_valid || o_cmd.ready);
    assign four     = i_head.four_mode;
    assign last_ch  = (r_ch == CH_W'(N_CH - 1));
    assign chan_end = four ? (r_step == STEP_B2) : (r_step == STEP_B1);
    assign item_end = chan_end && (!four || last_ch);
    assign ch2      = 2'(r_ch);
    assign code_s   = i_head.neg ? (~r_code + t_code'(1)) : r_code;

    always_comb begin
        byte_v = '0;
        if (four) begin
            case (r_step)
                STEP_B0: byte_v = MULTI_WRITE + t_byte'({ch2, 1'b1});
                STEP_B1: byte_v = (i_head.flag ? FLAG_INTERNAL : t_byte'(0))
                                  | t_byte'(r_code[CODE_W-1:8]);
                default: byte_v = r_code[7:0];
            endcase
        end else begin
            case (r_step)
                STEP_B0: byte_v = t_byte'(code_s[CODE_W-1:8]);
                default: byte_v = code_s[7:0];
            endcase
        end
    end

    always_comb begin
        src     = i_head;
        idx     = '0;
        load_en = 1'b0;
        if (!r_busy) begin
            load_en = i_stat.head_valid;
        end else if (emit && item_end) begin
            load_en = i_stat.next_valid;
            src     = i_next;
        end else if (emit && chan_end) begin
            load_en = 1'b1;
            idx     = CH_W'(r_ch + 1'b1);
        end
        m_k  = !src.four_mode ? K_SGL : (src.flag ? K_INT : K_EXT);
        prod = PROD_W'(src.mag[idx]) * PROD_W'(m_k);
    end

    always_comb begin
        n_busy = r_busy;
        n_ch   = r_ch;
        n_step = r_step;
        if (!r_busy) begin
            n_busy = i_stat.head_valid;
            n_ch   = '0;
            n_step = STEP_B0;
        end else if (emit) begin
            if (item_end) begin
                n_busy = i_stat.next_valid;
                n_ch   = '0;
                n_step = STEP_B0;
            end else if (chan_end) begin
                n_ch   = CH_W'(r_ch + 1'b1);
                n_step = STEP_B0;
            end else begin
                case (r_step)
                    STEP_B0: n_step = STEP_B1;
                    STEP_B1: n_step = STEP_B2;
                    default: n_step = STEP_B0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ch      <= '0;
            r_step    <= STEP_B0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ch   <= n_ch;
            r_step <= n_step;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_code <= prod[SHIFT+CODE_W-1:SHIFT];
        end
        if (emit) begin
            r_o_byte <= byte_v;
            r_o_last <= item_end;
        end
    end

    assign o_pop           = emit && item_end;
    assign o_cmd.valid     = r_o_valid;
    assign o_cmd.out_byte  = r_o_byte;
    assign o_cmd.last_byte = r_o_last;

    `DVCB_ASSERT_IMPL(a_busy_has_head, i_clk, i_rst_n, r_busy, i_stat.head_valid, "busy without a queued command")
    `DVCB_ASSERT_IMPL(a_idle_cleared, i_clk, i_rst_n, !r_busy, (r_ch == '0) && (r_step == STEP_B0), "idle sequencer not rewound")
    `DVCB_ASSERT_IMPL(a_single_steps, i_clk, i_rst_n, r_busy && !four, (r_ch == '0) && ((r_step == STEP_B0) || (r_step == STEP_B1)), "single-channel sequence out of range")
    `DVCB_ASSERT(a_pop_marks_last, i_clk, i_rst_n, o_pop |=> (r_o_valid && r_o_last), "pop without last byte")

endmodule

FILE: hw/rtl/dac_voltage_command_builder_unit.sv
// ----------------------------------------------------------------------------
// DAC voltage command builder
// Turns four channel levels in millivolts into the write byte stream of a
// 12-bit I2C DAC, one byte per output beat, last byte flagged.
//
// i_level carries one command (four 13-bit levels) per beat; o_cmd carries
// one command byte per beat, with last_byte on the final byte. The plain
// write port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the four-channel mode
// (index 0) and the signed single-channel offset (index 1); write it only
// while no command is in flight.
// Four-channel mode gives 12 bytes per command, single-channel mode 2.
// The byte sequencer emits one byte per cycle while a command is queued
// and o_cmd does not stall. The first byte of a command reaching an idle
// block is written to the queue slot, then scaled into the code register,
// then loaded into the output register before it appears on o_cmd.
// A two-entry queue sits between the front end and the sequencer, so
// i_level keeps taking beats while the sequencer works or o_cmd stalls;
// with the queue full, i_level.ready drops. A stalled o_cmd holds its byte.
// Reset empties the queue and output register and restores four-channel
// mode with zero offset.
// ----------------------------------------------------------------------------
module dac_voltage_command_builder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dvcb_level_if.sink          i_level,
    dvcb_byte_if.source         o_cmd,
    input  logic                i_cfg_we,
    input  dvcb_pkg::t_cfg_idx  i_cfg_idx,
    input  dvcb_pkg::t_cfg_data i_cfg_data
);
    import dvcb_pkg::*;

    logic    push_valid;
    logic    push_ready;
    t_cmd    push_cmd;
    t_cmd    head;
    t_cmd    next;
    t_q_stat q_stat;
    logic    pop;

    dvcb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_level      (i_level),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_cmd        (push_cmd)
    );

    dvcb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_cmd        (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head       (head),
        .o_next       (next),
        .o_stat       (q_stat)
    );

    dvcb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_next  (next),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_cmd   (o_cmd)
    );

endmodule
